FILE: rtl/core/qieg_pkg.sv
// Shared types and constants for the queued interval edge generator.
package qieg_pkg;

    // Item codes carried on the input channel
    typedef enum logic [1:0] {
        MODE_PUSH    = 2'd0,
        MODE_COMMIT  = 2'd1,
        MODE_TICK    = 2'd2,
        MODE_RESTART = 2'd3
    } t_mode;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_IDLE_HIGH     = 2'd0,
        CFG_WAKE_ON_EMPTY = 2'd1,
        CFG_WAKE_ON_LOW   = 2'd2,
        CFG_LOW_MARK      = 2'd3
    } t_cfg_idx;

    localparam int unsigned DELTA_W    = 16;
    localparam int unsigned LEVEL_W    = 5;
    localparam int unsigned CFG_DATA_W = 5;

    // Compare is armed this many ticks ahead of the counter on start
    localparam logic [DELTA_W-1:0] ARM_OFFSET = 16'd2;
    localparam logic [LEVEL_W-1:0] LOW_MARK_RST = 5'd8;

    typedef struct packed {
        logic               idle_high;
        logic               wake_on_empty;
        logic               wake_on_low;
        logic [LEVEL_W-1:0] low_mark;
    } t_cfg;

    typedef struct packed {
        logic               accepted;
        logic               line_level;
        logic               wake;
        logic               busy_res;
        logic [LEVEL_W-1:0] queue_length;
        logic [LEVEL_W-1:0] queue_space;
    } t_result;

endpackage

FILE: rtl/core/qieg_if.sv
// Valid/ready channel interfaces: item input, result output, config write.
interface qieg_in_if;
    logic                                valid;
    logic                                ready;
    qieg_pkg::t_mode                     mode;
    logic [qieg_pkg::DELTA_W-1:0]        delta;

    modport source (output valid, output mode, output delta, input ready);
    modport sink   (input valid, input mode, input delta, output ready);
endinterface

interface qieg_out_if;
    logic                                valid;
    logic                                ready;
    logic                                accepted;
    logic                                line_level;
    logic                                wake;
    logic                                busy_res;
    logic [qieg_pkg::LEVEL_W-1:0]        queue_length;
    logic [qieg_pkg::LEVEL_W-1:0]        queue_space;

    modport source (output valid, output accepted, output line_level, output wake,
                    output busy_res, output queue_length, output queue_space,
                    input ready);
    modport sink   (input valid, input accepted, input line_level, input wake,
                    input busy_res, input queue_length, input queue_space,
                    output ready);
endinterface

interface qieg_cfg_if;
    logic                                valid;
    logic                                ready;
    qieg_pkg::t_cfg_idx                  index;
    logic [qieg_pkg::CFG_DATA_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/core/qieg_ram.sv
// Generic single-write, single-read RAM with registered read data.
module qieg_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/qieg_core.sv
// Queue pointers, timer/compare state and the per-word update logic.
module qieg_core #(
    parameter int unsigned QUEUE_DEPTH = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_fire,
    input  qieg_pkg::t_mode                i_mode,
    input  logic [qieg_pkg::DELTA_W-1:0]   i_delta,
    input  qieg_pkg::t_cfg                 i_cfg,
    input  logic [qieg_pkg::DELTA_W-1:0]   i_ram_rdata,
    output logic                           o_ram_we,
    output logic [$clog2(QUEUE_DEPTH)-1:0] o_ram_waddr,
    output logic [qieg_pkg::DELTA_W-1:0]   o_ram_wdata,
    output logic [$clog2(QUEUE_DEPTH)-1:0] o_ram_raddr,
    output qieg_pkg::t_result              o_result
);

    localparam int unsigned IDX_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned EXT_W = IDX_W + qieg_pkg::LEVEL_W;
    localparam int unsigned DW    = qieg_pkg::DELTA_W;

    logic [IDX_W-1:0] r_committed, n_committed;
    logic [IDX_W-1:0] r_staged,    n_staged;
    logic [IDX_W-1:0] r_tail,      n_tail;
    logic [IDX_W:0]   r_wake_pos,  n_wake_pos;
    logic             r_running,   n_running;
    logic             r_rst_pend,  n_rst_pend;
    logic             r_toggle,    n_toggle;
    logic [DW-1:0]    r_tick,      n_tick;
    logic [DW-1:0]    r_cmp,       n_cmp;
    logic             r_pin,       n_pin;
    logic             r_byp_vld,   n_byp_vld;
    logic [DW-1:0]    r_byp_data;

    logic [DW-1:0]    head_val;
    logic [IDX_W-1:0] staged_inc;
    logic [IDX_W-1:0] tail_inc;
    logic [IDX_W-1:0] low_idx;
    logic [DW-1:0]    tick_inc;
    logic [EXT_W-1:0] low_ext;
    logic [EXT_W-1:0] len_ext;
    logic [EXT_W-1:0] space_ext;
    logic [IDX_W-1:0] len;
    logic             accepted;
    logic             wake;

    // Head entry: RAM prefetch, or the word written at that slot last cycle
    assign head_val   = r_byp_vld ? r_byp_data : i_ram_rdata;
    assign staged_inc = r_staged + 1'b1;
    assign tail_inc   = r_tail + 1'b1;
    assign tick_inc   = r_tick + 1'b1;
    assign low_ext    = {{IDX_W{1'b0}}, i_cfg.low_mark};
    assign low_idx    = r_staged - low_ext[IDX_W-1:0];

    // Per-word state update
    always_comb begin
        n_committed = r_committed;
        n_staged    = r_staged;
        n_tail      = r_tail;
        n_wake_pos  = r_wake_pos;
        n_running   = r_running;
        n_rst_pend  = r_rst_pend;
        n_toggle    = r_toggle;
        n_tick      = r_tick;
        n_cmp       = r_cmp;
        n_pin       = r_pin;
        accepted    = 1'b0;
        wake        = 1'b0;
        o_ram_we    = 1'b0;
        if (i_fire) begin
            unique case (i_mode)
                qieg_pkg::MODE_PUSH: begin
                    if (staged_inc != r_tail) begin
                        o_ram_we = 1'b1;
                        n_staged = staged_inc;
                        accepted = 1'b1;
                    end
                end
                qieg_pkg::MODE_COMMIT: begin
                    if (r_staged != r_committed) begin
                        if (r_running) begin
                            if (r_committed == r_tail) begin
                                n_rst_pend = 1'b1;
                            end
                        end else begin
                            n_running = 1'b1;
                            n_toggle  = 1'b1;
                            n_cmp     = r_tick + qieg_pkg::ARM_OFFSET;
                        end
                        n_committed = r_staged;
                        if (i_cfg.wake_on_low) begin
                            n_wake_pos = {1'b0, low_idx};
                        end
                    end
                end
                qieg_pkg::MODE_TICK: begin
                    n_tick = tick_inc;
                    if (tick_inc == r_cmp) begin
                        if (r_toggle) begin
                            n_pin = ~r_pin;
                        end
                        // Queue and compare updates act only while running; the pin toggle above does not
                        if (r_running) begin
                            if (r_rst_pend) begin
                                n_rst_pend = 1'b0;
                                n_toggle   = 1'b1;
                                n_cmp      = tick_inc + qieg_pkg::ARM_OFFSET;
                            end else if (r_tail != r_committed) begin
                                n_cmp  = r_cmp + head_val;
                                n_tail = tail_inc;
                                if (tail_inc == r_committed) begin
                                    n_toggle = 1'b0;
                                end
                                if ({1'b0, tail_inc} == r_wake_pos) begin
                                    wake = 1'b1;
                                end
                            end else begin
                                n_running = 1'b0;
                                wake      = i_cfg.wake_on_empty;
                            end
                        end
                    end
                end
                qieg_pkg::MODE_RESTART: begin
                    n_committed = '0;
                    n_staged    = '0;
                    n_tail      = '0;
                    n_wake_pos  = '1;
                    n_toggle    = 1'b0;
                    n_pin       = i_cfg.idle_high;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_ram_waddr = r_staged;
    assign o_ram_wdata = i_delta;
    assign o_ram_raddr = n_tail;
    assign n_byp_vld   = o_ram_we && (r_staged == n_tail);

    // Fill level and free space, taken to the 5-bit result fields
    assign len       = n_committed - n_tail;
    assign len_ext   = {{qieg_pkg::LEVEL_W{1'b0}}, len};
    assign space_ext = {{qieg_pkg::LEVEL_W{1'b0}}, ~len};

    always_comb begin
        o_result.accepted     = accepted;
        o_result.line_level   = n_pin;
        o_result.wake         = wake;
        o_result.busy_res     = n_running;
        o_result.queue_length = len_ext[qieg_pkg::LEVEL_W-1:0];
        o_result.queue_space  = space_ext[qieg_pkg::LEVEL_W-1:0];
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_committed <= '0;
            r_staged    <= '0;
            r_tail      <= '0;
            r_wake_pos  <= '1;
            r_running   <= 1'b0;
            r_rst_pend  <= 1'b0;
            r_toggle    <= 1'b0;
            r_tick      <= '0;
            r_cmp       <= '0;
            r_pin       <= 1'b0;
            r_byp_vld   <= 1'b0;
        end else begin
            r_committed <= n_committed;
            r_staged    <= n_staged;
            r_tail      <= n_tail;
            r_wake_pos  <= n_wake_pos;
            r_running   <= n_running;
            r_rst_pend  <= n_rst_pend;
            r_toggle    <= n_toggle;
            r_tick      <= n_tick;
            r_cmp       <= n_cmp;
            r_pin       <= n_pin;
            r_byp_vld   <= n_byp_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byp_data <= i_delta;
    end

endmodule

FILE: rtl/core/queued_interval_edge_generator_unit.sv
// Top level: input register, update core with interval RAM, result register.
// Each word on i_in yields exactly one result word on o_out. A word is taken
// into an input register, processed by the update core against the interval
// RAM (its read port prefetches the head entry so a compare event consumes a
// delta without waiting) once the result register is free or draining, and
// lands in the result register. One word per clock is sustained while o_out
// is ready, the rate set by the single pass of the update core. Config writes
// are taken at once and should only be issued with no words in flight.
// Unpushed RAM entries are never read, so the RAM needs no clearing after reset.
module queued_interval_edge_generator_unit #(
    parameter int unsigned QUEUE_DEPTH = 32
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    qieg_in_if.sink         i_in,
    qieg_out_if.source      o_out,
    qieg_cfg_if.sink        i_cfg
);

    localparam int unsigned IDX_W = $clog2(QUEUE_DEPTH);

    logic                          r_in_vld;
    qieg_pkg::t_mode               r_mode;
    logic [qieg_pkg::DELTA_W-1:0]  r_delta;
    logic                          r_out_vld;
    qieg_pkg::t_result             r_result;
    qieg_pkg::t_cfg                r_cfg;

    logic                          fire;
    qieg_pkg::t_result             result;
    logic                          ram_we;
    logic [IDX_W-1:0]              ram_waddr;
    logic [IDX_W-1:0]              ram_raddr;
    logic [qieg_pkg::DELTA_W-1:0]  ram_wdata;
    logic [qieg_pkg::DELTA_W-1:0]  ram_rdata;

    // Process the held word when the result register is free or draining
    assign fire        = r_in_vld && (!r_out_vld || o_out.ready);
    assign i_in.ready  = !r_in_vld || fire;
    assign i_cfg.ready = 1'b1;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_in.ready) begin
            r_in_vld <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_mode  <= i_in.mode;
            r_delta <= i_in.delta;
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.idle_high     <= 1'b0;
            r_cfg.wake_on_empty <= 1'b0;
            r_cfg.wake_on_low   <= 1'b0;
            r_cfg.low_mark      <= qieg_pkg::LOW_MARK_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                qieg_pkg::CFG_IDLE_HIGH:     r_cfg.idle_high     <= i_cfg.data[0];
                qieg_pkg::CFG_WAKE_ON_EMPTY: r_cfg.wake_on_empty <= i_cfg.data[0];
                qieg_pkg::CFG_WAKE_ON_LOW:   r_cfg.wake_on_low   <= i_cfg.data[0];
                qieg_pkg::CFG_LOW_MARK:      r_cfg.low_mark      <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    qieg_core #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_mode      (r_mode),
        .i_delta     (r_delta),
        .i_cfg       (r_cfg),
        .i_ram_rdata (ram_rdata),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_raddr (ram_raddr),
        .o_result    (result)
    );

    qieg_ram #(
        .WIDTH (qieg_pkg::DELTA_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (fire) begin
            r_out_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_result <= result;
        end
    end

    assign o_out.valid        = r_out_vld;
    assign o_out.accepted     = r_result.accepted;
    assign o_out.line_level   = r_result.line_level;
    assign o_out.wake         = r_result.wake;
    assign o_out.busy_res     = r_result.busy_res;
    assign o_out.queue_length = r_result.queue_length;
    assign o_out.queue_space  = r_result.queue_space;

endmodule

FILE: rtl/core/qieg_checker.sv
// Port-level checks for the edge generator, bound to the top level.
module qieg_checker #(
    parameter int unsigned QUEUE_DEPTH = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_out_valid,
    input  logic                         i_out_ready,
    input  logic                         i_out_busy_res,
    input  logic [qieg_pkg::LEVEL_W-1:0] i_out_queue_length,
    input  logic [qieg_pkg::LEVEL_W-1:0] i_out_queue_space
);

    localparam logic [qieg_pkg::LEVEL_W-1:0] FILL_SUM =
        qieg_pkg::LEVEL_W'((QUEUE_DEPTH - 1) % 32);

    logic [qieg_pkg::LEVEL_W-1:0] fill_sum;
    assign fill_sum = i_out_queue_length + i_out_queue_space;

    // Length and space always add up to one less than the ring depth
    a_fill_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> fill_sum == FILL_SUM)
        else $error("queue length and space do not add up");

    // A stopped generator has consumed every committed entry
    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_busy_res) |-> i_out_queue_length == '0)
        else $error("generator idle with committed entries left");

    // No result is offered right after reset
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    // A stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("result dropped while stalled");

endmodule

bind queued_interval_edge_generator_unit qieg_checker #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
) u_qieg_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_out_valid        (o_out.valid),
    .i_out_ready        (o_out.ready),
    .i_out_busy_res     (o_out.busy_res),
    .i_out_queue_length (o_out.queue_length),
    .i_out_queue_space  (o_out.queue_space)
);

FILE: sim/tb_top.sv
// Testbench for the queued interval edge generator: directed and random streams checked against a predictor.
module tb_top;
    import qieg_pkg::*;

    localparam int unsigned RING_DEPTH  = 32;
    localparam int          CYCLE_LIMIT = 1_500_000;
    localparam int          PHASE_WORDS = 225;
    localparam int          LONG_WAIT   = 64;

    // Tracks the generator state and the result words it still owes
    class edge_train_scoreboard;
        logic [DELTA_W-1:0] ring [RING_DEPTH];
        logic [4:0]         committed_head;
        logic [4:0]         staged_head;
        logic [4:0]         read_tail;
        logic [5:0]         wake_pos;
        bit                 running;
        bit                 restart_pending;
        bit                 toggle_on;
        logic [DELTA_W-1:0] tick_count;
        logic [DELTA_W-1:0] compare_val;
        bit                 pin;
        bit                 idle_high;
        bit                 wake_on_empty;
        bit                 wake_on_low;
        logic [4:0]         low_mark;
        t_result            pending_results [$];
        int                 errors;

        function new();
            foreach (ring[i]) ring[i] = '0;
            committed_head  = '0;
            staged_head     = '0;
            read_tail       = '0;
            wake_pos        = '1;
            running         = 0;
            restart_pending = 0;
            toggle_on       = 0;
            tick_count      = '0;
            compare_val     = '0;
            idle_high       = 0;
            wake_on_empty   = 0;
            wake_on_low     = 0;
            low_mark        = LOW_MARK_RST;
            pin             = 0;
            errors          = 0;
        endfunction

        function void set_reg(t_cfg_idx idx, logic [4:0] val);
            case (idx)
                CFG_IDLE_HIGH:     idle_high     = val[0];
                CFG_WAKE_ON_EMPTY: wake_on_empty = val[0];
                CFG_WAKE_ON_LOW:   wake_on_low   = val[0];
                CFG_LOW_MARK:      low_mark      = val;
                default: ;
            endcase
        endfunction

        function logic [4:0] queue_length();
            logic [4:0] len;
            len = committed_head - read_tail;
            return len;
        endfunction

        // pushes the ring takes before it refuses
        function int staged_room();
            logic [4:0] room;
            room = read_tail - staged_head - 5'd1;
            return room;
        endfunction

        function int ticks_to_match();
            logic [DELTA_W-1:0] diff;
            diff = compare_val - tick_count;
            return (diff == 0) ? 65536 : int'(diff);
        endfunction

        function int outstanding();
            return pending_results.size();
        endfunction

        // compare event handler; returns the wake pulse
        function bit fire_compare();
            bit w;
            w = 0;
            if (!running) return 0;
            if (restart_pending) begin
                restart_pending = 0;
                toggle_on       = 1;
                compare_val     = tick_count + ARM_OFFSET;
            end else if (read_tail != committed_head) begin
                compare_val = compare_val + ring[read_tail];
                read_tail   = read_tail + 5'd1;
                if (read_tail == committed_head) toggle_on = 0;
                if ({1'b0, read_tail} == wake_pos) w = 1;
            end else begin
                running = 0;
                if (wake_on_empty) w = 1;
            end
            return w;
        endfunction

        // accepted input word: advance the state and queue its result word
        function void note_word(t_mode mode, logic [DELTA_W-1:0] delta);
            t_result    r;
            logic [4:0] nxt;
            logic [4:0] pos;
            r = '0;
            case (mode)
                MODE_PUSH: begin
                    nxt = staged_head + 5'd1;
                    if (nxt != read_tail) begin
                        ring[staged_head] = delta;
                        staged_head       = nxt;
                        r.accepted        = 1'b1;
                    end
                end
                MODE_COMMIT: begin
                    if (staged_head != committed_head) begin
                        if (running) begin
                            if (committed_head == read_tail) restart_pending = 1;
                        end else begin
                            running     = 1;
                            toggle_on   = 1;
                            compare_val = tick_count + ARM_OFFSET;
                        end
                        committed_head = staged_head;
                        if (wake_on_low) begin
                            pos      = committed_head - low_mark;
                            wake_pos = {1'b0, pos};
                        end
                    end
                end
                MODE_TICK: begin
                    tick_count = tick_count + 16'd1;
                    if (tick_count == compare_val) begin
                        if (toggle_on) pin = ~pin;
                        r.wake = fire_compare();
                    end
                end
                default: begin
                    committed_head = '0;
                    staged_head    = '0;
                    read_tail      = '0;
                    wake_pos       = '1;
                    toggle_on      = 0;
                    pin            = idle_high;
                end
            endcase
            r.line_level   = pin;
            r.busy_res     = running;
            r.queue_length = queue_length();
            r.queue_space  = 5'd31 - r.queue_length;
            pending_results.push_back(r);
        endfunction

        function void flag_field(string name, logic [4:0] want, logic [4:0] seen);
            if (want !== seen) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, seen);
                errors++;
            end
        endfunction

        function void check_word(t_result seen);
            t_result want;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result word %h", $time, seen);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            flag_field("accepted",     want.accepted,     seen.accepted);
            flag_field("line_level",   want.line_level,   seen.line_level);
            flag_field("wake",         want.wake,         seen.wake);
            flag_field("busy_res",     want.busy_res,     seen.busy_res);
            flag_field("queue_length", want.queue_length, seen.queue_length);
            flag_field("queue_space",  want.queue_space,  seen.queue_space);
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    qieg_in_if  in_ch ();
    qieg_out_if out_ch ();
    qieg_cfg_if cfg_ch ();

    queued_interval_edge_generator_unit #(
        .QUEUE_DEPTH (RING_DEPTH)
    ) u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    edge_train_scoreboard sb;
    bit quiet_run;
    bit tail_phase;
    int items_done;
    int n_results;
    int cycles;
    int wrap_budget;
    int big_count;

    always #6 clk = ~clk;

    // run limit
    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("queued_interval_edge_generator_unit test failed");
            $finish;
        end
    end

    function automatic bit may_idle();
        return !quiet_run && !tail_phase;
    endfunction

    function automatic logic [DELTA_W-1:0] short_delta();
        if ($urandom_range(0, 7) == 0) return DELTA_W'($urandom_range(7, 40));
        return DELTA_W'($urandom_range(1, 6));
    endfunction

    // result monitor
    always @(posedge clk) begin : watch_results
        t_result seen;
        if (rst_n && out_ch.valid && out_ch.ready) begin
            seen.accepted     = out_ch.accepted;
            seen.line_level   = out_ch.line_level;
            seen.wake         = out_ch.wake;
            seen.busy_res     = out_ch.busy_res;
            seen.queue_length = out_ch.queue_length;
            seen.queue_space  = out_ch.queue_space;
            sb.check_word(seen);
            n_results++;
        end
    end

    // receiver: random stall bursts plus one long hold while words keep coming
    initial begin : receiver
        int  stall;
        bit  held_long;
        stall     = 0;
        held_long = 0;
        out_ch.ready <= 1'b0;
        while (rst_n !== 1'b1) @(posedge clk);
        forever begin
            @(posedge clk);
            if (!held_long && n_results >= 300 && in_ch.valid && may_idle()) begin
                held_long = 1;
                stall     = 150;
            end
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                stall--;
            end else if (may_idle() && $urandom_range(0, 15) == 0) begin
                stall = $urandom_range(0, 18);
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // one input word; valid stays high for a following word
    task automatic send_word(input t_mode mode, input logic [DELTA_W-1:0] delta);
        int gap;
        if (may_idle() && $urandom_range(0, 15) == 0) begin
            gap = $urandom_range(1, 19);
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.mode  <= mode;
        in_ch.delta <= delta;
        do @(posedge clk); while (in_ch.ready !== 1'b1);
        sb.note_word(mode, delta);
        if (!quiet_run) items_done++;
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [4:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge clk); while (cfg_ch.ready !== 1'b1);
        sb.set_reg(idx, val);
    endtask

    task automatic load_config(input logic [4:0] ih, input logic [4:0] we,
                               input logic [4:0] wl, input logic [4:0] lm);
        write_reg(CFG_IDLE_HIGH, ih);
        write_reg(CFG_WAKE_ON_EMPTY, we);
        write_reg(CFG_WAKE_ON_LOW, wl);
        write_reg(CFG_LOW_MARK, lm);
        cfg_ch.valid <= 1'b0;
    endtask

    // stop offering and wait for every owed result word
    task automatic settle();
        in_ch.valid <= 1'b0;
        while (sb.outstanding() > 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // tick until the generator stops or the cap runs out; long intervals run without idling
    task automatic tick_until_stopped(input int cap);
        int n;
        while (sb.running && cap > 0) begin
            n = sb.ticks_to_match();
            if (n > LONG_WAIT) begin
                quiet_run = 1;
                repeat (n) send_word(MODE_TICK, DELTA_W'($urandom));
                quiet_run = 0;
                cap -= n;
            end else begin
                send_word(MODE_TICK, DELTA_W'($urandom));
                cap--;
            end
        end
    endtask

    // commit while the last interval runs (restart mark), optionally restart,
    // then let a compare match hit the stopped generator with toggling on
    task automatic mark_last_interval(input bit do_restart);
        int k;
        if (!sb.running) begin
            send_word(MODE_PUSH, short_delta());
            send_word(MODE_COMMIT, DELTA_W'($urandom));
        end
        while (sb.running && sb.queue_length() > 0) send_word(MODE_TICK, '0);
        if (sb.running) begin
            k = $urandom_range(1, 3);
            repeat (k) send_word(MODE_PUSH, short_delta());
            send_word(MODE_COMMIT, '0);
        end
        if (do_restart) send_word(MODE_RESTART, DELTA_W'($urandom));
        tick_until_stopped(5000);
        if (!sb.running && sb.toggle_on && wrap_budget > 0) begin
            wrap_budget--;
            k = sb.ticks_to_match();
            quiet_run = 1;
            repeat (k) send_word(MODE_TICK, '0);
            quiet_run = 0;
        end
    endtask

    // well-formed pulse train with random traffic mixed in while it runs
    task automatic run_train(input bit with_long);
        int                 k;
        int                 extra;
        int                 r;
        logic [DELTA_W-1:0] d;
        if ($urandom_range(0, 3) == 0) send_word(MODE_RESTART, DELTA_W'($urandom));
        k = $urandom_range(1, 10);
        for (int j = 0; j < k; j++) begin
            d = short_delta();
            if (with_long && j == k / 2) begin
                d = (big_count == 0) ? '0 : DELTA_W'($urandom_range(0, 65535));
                big_count++;
            end
            send_word(MODE_PUSH, d);
        end
        send_word(MODE_COMMIT, DELTA_W'($urandom));
        extra = $urandom_range(4, 50);
        for (int j = 0; j < extra; j++) begin
            r = $urandom_range(0, 39);
            if (r < 5)
                send_word(MODE_PUSH, short_delta());
            else if (r < 9)
                send_word(MODE_COMMIT, DELTA_W'($urandom));
            else if (r == 9)
                send_word(MODE_RESTART, DELTA_W'($urandom));
            else
                send_word(MODE_TICK, DELTA_W'($urandom));
        end
        tick_until_stopped(200_000);
    endtask

    // fill the ring, then offer refused words with full-range deltas
    task automatic fill_ring();
        int k;
        if ($urandom_range(0, 1) == 0) send_word(MODE_RESTART, DELTA_W'($urandom));
        while (sb.staged_room() > 0) send_word(MODE_PUSH, short_delta());
        k = $urandom_range(1, 4);
        repeat (k) send_word(MODE_PUSH, DELTA_W'($urandom_range(0, 65535)));
        if ($urandom_range(0, 1) == 0) begin
            send_word(MODE_COMMIT, DELTA_W'($urandom));
            tick_until_stopped(5000);
        end else begin
            send_word(MODE_RESTART, DELTA_W'($urandom));
        end
    endtask

    // unstructured words of every kind
    task automatic send_noise();
        int    k;
        t_mode m;
        k = $urandom_range(5, 20);
        repeat (k) begin
            m = t_mode'($urandom_range(0, 3));
            send_word(m, (m == MODE_PUSH) ? short_delta() : DELTA_W'($urandom_range(0, 65535)));
        end
    endtask

    initial begin : stimulus
        int phase_goal;
        int pick;
        sb          = new();
        quiet_run   = 0;
        tail_phase  = 0;
        items_done  = 0;
        n_results   = 0;
        cycles      = 0;
        wrap_budget = 1;
        big_count   = 0;
        rst_n        <= 1'b0;
        in_ch.valid  <= 1'b0;
        in_ch.mode   <= MODE_TICK;
        in_ch.delta  <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= CFG_IDLE_HIGH;
        cfg_ch.data  <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty commit, extreme deltas discarded by restart,
        // a short train, restart mark, match while stopped in toggle mode
        load_config(5'd0, 5'd1, 5'd1, 5'd1);
        send_word(MODE_COMMIT, 16'hFFFF);
        send_word(MODE_TICK, 16'h0000);
        send_word(MODE_PUSH, 16'hFFFF);
        send_word(MODE_PUSH, 16'h0000);
        send_word(MODE_RESTART, 16'hA5A5);
        send_word(MODE_PUSH, 16'd2);
        send_word(MODE_PUSH, 16'd1);
        send_word(MODE_PUSH, 16'd3);
        send_word(MODE_COMMIT, 16'd0);
        tick_until_stopped(200);
        mark_last_interval(1'b1);
        send_word(MODE_RESTART, 16'd0);

        // random phases, each under its own register setting
        for (int phase = 0; phase < 6; phase++) begin
            settle();
            case (phase)
                0: load_config(5'd1, 5'd0, 5'd1, 5'd0);
                1: load_config(5'd0, 5'd1, 5'd0, 5'd31);
                default: load_config(5'($urandom), 5'($urandom), 5'($urandom),
                                     5'($urandom_range(0, 31)));
            endcase
            tail_phase = (phase == 5);
            if (phase == 1 || phase == 3) run_train(1'b1);
            phase_goal = items_done + PHASE_WORDS;
            while (items_done < phase_goal) begin
                pick = $urandom_range(0, 9);
                if (pick < 5)
                    run_train(1'b0);
                else if (pick < 7)
                    mark_last_interval($urandom_range(0, 1));
                else if (pick == 7)
                    fill_ring();
                else
                    send_noise();
            end
        end

        settle();
        repeat (8) @(posedge clk);
        if (sb.errors == 0)
            $display("queued_interval_edge_generator_unit test passed");
        else
            $display("queued_interval_edge_generator_unit test failed");
        $finish;
    end

endmodule
